[design/geometric_interval_subdivider_macros.svh]
// ---------------------------------------------------------------------------
// geometric interval subdivider assertion macros
// shared property forms for the design's checks
// ---------------------------------------------------------------------------
`ifndef GEOMETRIC_INTERVAL_SUBDIVIDER_MACROS_SVH
`define GEOMETRIC_INTERVAL_SUBDIVIDER_MACROS_SVH

// same-cycle implication
`define GIS_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GIS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/gis_pkg.sv]
// ---------------------------------------------------------------------------
// gis_pkg
// shared types and constants of the geometric interval subdivider
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gis_pkg;

  localparam int MAX_SEGMENTS_DEF    = 64;
  localparam int COORD_WIDTH_DEF     = 32;
  localparam int RATIO_FRAC_BITS_DEF = 24;

  localparam int RATIO_WIDTH  = 32;
  localparam int COUNT_WIDTH  = 7;
  localparam int INDEX_WIDTH  = 6;
  localparam int STATUS_WIDTH = 2;
  localparam int WFRAC        = 30;
  localparam int DIV_BITS     = RATIO_WIDTH + WFRAC;
  localparam int DCNT_WIDTH   = $clog2(DIV_BITS);

  localparam logic [STATUS_WIDTH-1:0] ST_POINT = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_BAD   = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_OVF   = 2'd3;

  typedef struct packed {
    logic [STATUS_WIDTH-1:0] status;
    logic                    unit;
  } item_ctl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_POW,
    BK_PREP,
    BK_DIV,
    BK_SUM,
    BK_MUL,
    BK_EMIT
  } back_state_t;

endpackage

[design/gis_if.sv]
// ---------------------------------------------------------------------------
// gis channel interfaces
// input interval channel and result channel, valid/ready handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gis_in_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic [6:0]           segment_count;
  logic [31:0]          ratio;

  modport source(output valid, start_x, start_y, end_x, end_y, segment_count, ratio,
                 input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, segment_count, ratio,
               output ready);
endinterface

interface gis_out_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic [5:0]           point_index;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic [1:0]           status;
  logic                 last;

  modport source(output valid, point_index, point_x, point_y, status, last, input ready);
  modport sink(input valid, point_index, point_x, point_y, status, last, output ready);
endinterface

[design/gis_front.sv]
// ---------------------------------------------------------------------------
// gis_front
// classifies incoming intervals and forms the axis lengths
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gis_front #(
  parameter int CW   = gis_pkg::COORD_WIDTH_DEF,
  parameter int MAXS = gis_pkg::MAX_SEGMENTS_DEF,
  parameter int RFB  = gis_pkg::RATIO_FRAC_BITS_DEF
) (
  gis_in_if.sink                          in_ch,
  output logic                            push,
  output gis_pkg::item_ctl_t              push_ctl,
  output logic [gis_pkg::COUNT_WIDTH-1:0] push_n,
  output logic [gis_pkg::RATIO_WIDTH-1:0] push_q,
  output logic [CW-1:0]                   push_sx,
  output logic [CW-1:0]                   push_sy,
  output logic [CW:0]                     push_magx,
  output logic [CW:0]                     push_magy,
  output logic                            push_negx,
  output logic                            push_negy,
  input  logic                            full
);
  import gis_pkg::*;

  localparam logic [RATIO_WIDTH-1:0] QONE = RATIO_WIDTH'(64'(1) << RFB);

  logic [CW:0] lx, ly;
  logic        bad;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  assign bad = (in_ch.segment_count == '0) ||
               (in_ch.segment_count > COUNT_WIDTH'(MAXS)) ||
               (in_ch.ratio == '0);

  always_comb begin
    if (bad) begin
      push_ctl.status = ST_BAD;
    end else if (in_ch.segment_count == COUNT_WIDTH'(1)) begin
      push_ctl.status = ST_EMPTY;
    end else begin
      push_ctl.status = ST_POINT;
    end
    push_ctl.unit = (in_ch.ratio == QONE);
  end

  // lengths need one extra bit
  assign lx = {in_ch.end_x[CW-1], in_ch.end_x} - {in_ch.start_x[CW-1], in_ch.start_x};
  assign ly = {in_ch.end_y[CW-1], in_ch.end_y} - {in_ch.start_y[CW-1], in_ch.start_y};

  assign push_negx = lx[CW];
  assign push_negy = ly[CW];
  assign push_magx = lx[CW] ? -lx : lx;
  assign push_magy = ly[CW] ? -ly : ly;
  assign push_n    = in_ch.segment_count;
  assign push_q    = in_ch.ratio;
  assign push_sx   = in_ch.start_x;
  assign push_sy   = in_ch.start_y;

endmodule

[design/gis_queue.sv]
// ---------------------------------------------------------------------------
// gis_queue
// two-entry queue between the classifier and the subdivision engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gis_queue #(
  parameter int CW = gis_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  gis_pkg::item_ctl_t              push_ctl,
  input  logic [gis_pkg::COUNT_WIDTH-1:0] push_n,
  input  logic [gis_pkg::RATIO_WIDTH-1:0] push_q,
  input  logic [CW-1:0]                   push_sx,
  input  logic [CW-1:0]                   push_sy,
  input  logic [CW:0]                     push_magx,
  input  logic [CW:0]                     push_magy,
  input  logic                            push_negx,
  input  logic                            push_negy,
  output logic                            full,
  input  logic                            pop,
  output logic                            head_valid,
  output gis_pkg::item_ctl_t              head_ctl,
  output logic [gis_pkg::COUNT_WIDTH-1:0] head_n,
  output logic [gis_pkg::RATIO_WIDTH-1:0] head_q,
  output logic [CW-1:0]                   head_sx,
  output logic [CW-1:0]                   head_sy,
  output logic [CW:0]                     head_magx,
  output logic [CW:0]                     head_magy,
  output logic                            head_negx,
  output logic                            head_negy
);
  import gis_pkg::*;

  localparam int EW = $bits(item_ctl_t) + COUNT_WIDTH + RATIO_WIDTH + 2 * CW + 2 * (CW + 1) + 2;

  logic [1:0]    cnt_r, cnt_nxt;
  logic [EW-1:0] head_r, tail_r, entry;
  logic          do_pop;

  assign entry = {push_ctl, push_n, push_q, push_sx, push_sy,
                  push_magx, push_magy, push_negx, push_negy};
  assign {head_ctl, head_n, head_q, head_sx, head_sy,
          head_magx, head_magy, head_negx, head_negy} = head_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (cnt_r == 2'd2) begin
        head_r <= tail_r;
        if (push) begin
          tail_r <= entry;
        end
      end else if (push) begin
        head_r <= entry;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        head_r <= entry;
      end else begin
        tail_r <= entry;
      end
    end
  end

endmodule

[design/gis_back.sv]
// ---------------------------------------------------------------------------
// gis_back
// power loop, serial divider and step loop that place the interior points
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "geometric_interval_subdivider_macros.svh"

module gis_back #(
  parameter int CW  = gis_pkg::COORD_WIDTH_DEF,
  parameter int RFB = gis_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  output logic                            pop,
  input  logic                            head_valid,
  input  gis_pkg::item_ctl_t              head_ctl,
  input  logic [gis_pkg::COUNT_WIDTH-1:0] head_n,
  input  logic [gis_pkg::RATIO_WIDTH-1:0] head_q,
  input  logic [CW-1:0]                   head_sx,
  input  logic [CW-1:0]                   head_sy,
  input  logic [CW:0]                     head_magx,
  input  logic [CW:0]                     head_magy,
  input  logic                            head_negx,
  input  logic                            head_negy,
  gis_out_if.source                       out_ch
);
  import gis_pkg::*;

  localparam int PW = CW + WFRAC + 2;
  localparam int GW = WFRAC + 1 + RATIO_WIDTH;
  localparam logic [RATIO_WIDTH-1:0] QONE = RATIO_WIDTH'(64'(1) << RFB);
  localparam logic [WFRAC:0]         WONE = {1'b1, {WFRAC{1'b0}}};

  back_state_t state_r, state_nxt;

  logic [CW-1:0]              sx_r, sy_r;
  logic [CW:0]                magx_r, magy_r;
  logic                       negx_r, negy_r;
  logic [COUNT_WIDTH-1:0]     n_r, k_r;
  logic [RATIO_WIDTH-1:0]     q_r, p_r;
  logic [STATUS_WIDTH-1:0]    st_r;
  logic                       unit_r;
  logic [INDEX_WIDTH-1:0]     i_r;

  logic [2*RATIO_WIDTH-1:0]   pprod, pshift;
  logic                       pow_ovf;
  logic [RATIO_WIDTH-1:0]     nm, dm;

  logic [DIV_BITS-1:0]        dividend_r, quo_r, quo_nxt;
  logic [RATIO_WIDTH-1:0]     divisor_r, rem_r, rem_nxt;
  logic [DCNT_WIDTH-1:0]      dcnt_r;
  logic [RATIO_WIDTH:0]       rem_sh;
  logic                       div_ge, div_last;
  logic [WFRAC:0]             fcap;

  logic [WFRAC:0]             g_r, s_r, scap, gcap;
  logic [WFRAC+1:0]           ssum;
  logic [PW-1:0]              mx_r, my_r;
  logic [GW-1:0]              gp_r, gshift;
  logic [CW:0]                sclx, scly, ptx, pty;
  logic                       is_last, slot_free, out_load;

  logic                       out_valid_r;
  logic [INDEX_WIDTH-1:0]     out_index_r;
  logic [CW-1:0]              out_x_r, out_y_r;
  logic [STATUS_WIDTH-1:0]    out_status_r;
  logic                       out_last_r;

  // power step
  assign pprod   = {{RATIO_WIDTH{1'b0}}, p_r} * {{RATIO_WIDTH{1'b0}}, q_r};
  assign pshift  = pprod >> RFB;
  assign pow_ovf = |pshift[2*RATIO_WIDTH-1:RATIO_WIDTH];

  assign nm = (q_r > QONE) ? q_r - QONE : QONE - q_r;
  assign dm = (p_r > QONE) ? p_r - QONE : QONE - p_r;

  // restoring divider, one quotient bit a cycle
  assign rem_sh   = {rem_r, dividend_r[DIV_BITS-1]};
  assign div_ge   = rem_sh >= {1'b0, divisor_r};
  assign rem_nxt  = div_ge ? RATIO_WIDTH'(rem_sh - {1'b0, divisor_r}) : rem_sh[RATIO_WIDTH-1:0];
  assign quo_nxt  = {quo_r[DIV_BITS-2:0], div_ge};
  assign div_last = (dcnt_r == DCNT_WIDTH'(DIV_BITS - 1));
  assign fcap     = (quo_nxt > DIV_BITS'(WONE)) ? WONE : quo_nxt[WFRAC:0];

  // step loop
  assign ssum   = {1'b0, s_r} + {1'b0, g_r};
  assign scap   = (ssum > {1'b0, WONE}) ? WONE : ssum[WFRAC:0];
  assign gshift = gp_r >> RFB;
  assign gcap   = (gshift > GW'(WONE)) ? WONE : gshift[WFRAC:0];
  assign sclx   = mx_r[WFRAC +: CW+1];
  assign scly   = my_r[WFRAC +: CW+1];
  assign ptx    = {sx_r[CW-1], sx_r} + (negx_r ? -sclx : sclx);
  assign pty    = {sy_r[CW-1], sy_r} + (negy_r ? -scly : scly);
  assign is_last = ({1'b0, i_r} == n_r - COUNT_WIDTH'(1));

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          if (head_ctl.status != ST_POINT) begin
            state_nxt = BK_EMIT;
          end else if (head_ctl.unit) begin
            state_nxt = BK_PREP;
          end else begin
            state_nxt = BK_POW;
          end
        end
      end
      BK_POW: begin
        if (pow_ovf) begin
          state_nxt = BK_EMIT;
        end else if (k_r == n_r) begin
          state_nxt = BK_PREP;
        end
      end
      BK_PREP: state_nxt = BK_DIV;
      BK_DIV: begin
        if (div_last) begin
          state_nxt = BK_SUM;
        end
      end
      BK_SUM: state_nxt = BK_MUL;
      BK_MUL: state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (slot_free) begin
          if (st_r != ST_POINT || is_last) begin
            state_nxt = BK_IDLE;
          end else begin
            state_nxt = BK_SUM;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state_r == BK_IDLE) && head_valid;
    out_load = (state_r == BK_EMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          sx_r   <= head_sx;
          sy_r   <= head_sy;
          magx_r <= head_magx;
          magy_r <= head_magy;
          negx_r <= head_negx;
          negy_r <= head_negy;
          n_r    <= head_n;
          q_r    <= head_q;
          st_r   <= head_ctl.status;
          unit_r <= head_ctl.unit;
          p_r    <= QONE;
          k_r    <= COUNT_WIDTH'(1);
        end
      end
      BK_POW: begin
        if (pow_ovf) begin
          st_r <= ST_OVF;
        end else begin
          p_r <= pshift[RATIO_WIDTH-1:0];
          k_r <= k_r + COUNT_WIDTH'(1);
        end
      end
      BK_PREP: begin
        // ratio of one, or a flat power, falls back to equal steps
        if (unit_r || dm == '0) begin
          dividend_r <= DIV_BITS'(WONE);
          divisor_r  <= RATIO_WIDTH'(n_r);
        end else begin
          dividend_r <= {nm, {WFRAC{1'b0}}};
          divisor_r  <= dm;
        end
        rem_r  <= '0;
        quo_r  <= '0;
        dcnt_r <= '0;
      end
      BK_DIV: begin
        dividend_r <= {dividend_r[DIV_BITS-2:0], 1'b0};
        rem_r      <= rem_nxt;
        quo_r      <= quo_nxt;
        dcnt_r     <= dcnt_r + DCNT_WIDTH'(1);
        if (div_last) begin
          g_r <= fcap;
          s_r <= '0;
          i_r <= INDEX_WIDTH'(1);
        end
      end
      BK_SUM: s_r <= scap;
      BK_MUL: begin
        mx_r <= PW'(magx_r) * PW'(s_r);
        my_r <= PW'(magy_r) * PW'(s_r);
        gp_r <= GW'(g_r) * GW'(q_r);
      end
      BK_EMIT: begin
        if (slot_free && st_r == ST_POINT) begin
          g_r <= gcap;
          i_r <= i_r + INDEX_WIDTH'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (st_r != ST_POINT) begin
        out_index_r <= '0;
        out_x_r     <= '0;
        out_y_r     <= '0;
        out_last_r  <= 1'b1;
      end else begin
        out_index_r <= i_r;
        out_x_r     <= ptx[CW-1:0];
        out_y_r     <= pty[CW-1:0];
        out_last_r  <= is_last;
      end
      out_status_r <= st_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.point_index = out_index_r;
  assign out_ch.point_x     = out_x_r;
  assign out_ch.point_y     = out_y_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last        = out_last_r;

  `GIS_CHECK(a_status_closes, out_valid_r && out_status_r != ST_POINT, out_last_r && out_index_r == '0, "status word must close its item")
  `GIS_CHECK(a_point_index, out_valid_r && out_status_r == ST_POINT, out_index_r != '0, "point word with index zero")
  `GIS_CHECK(a_sum_capped, state_r == BK_MUL, s_r <= WONE, "step sum above one")
  `GIS_NEXT(a_prep_div, state_r == BK_PREP, state_r == BK_DIV, "divider did not start after setup")

endmodule

[design/geometric_interval_subdivider.sv]
// ---------------------------------------------------------------------------
// geometric_interval_subdivider
// geometrically graded interior points of a 2-d interval
// ---------------------------------------------------------------------------
// Takes one interval word (start, end, segment count n, ratio q) and returns
// the n-1 interior points, index 1 first, with last set on the final one; bad
// counts or ratios, a count of one and an overflowing q^n each give a single
// status word. A point interval passes through the power loop (skipped when
// q is exactly 1.0), a setup step, the serial divider (one quotient bit a
// cycle) and the shared step loop. A two-entry queue lets new intervals be
// taken while the engine works and while a result word waits on the output
// register.
`timescale 1ns / 1ps

module geometric_interval_subdivider #(
  parameter int MAX_SEGMENTS    = gis_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_WIDTH     = gis_pkg::COORD_WIDTH_DEF,
  parameter int RATIO_FRAC_BITS = gis_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gis_in_if.sink    in_ch,
  gis_out_if.source out_ch
);
  import gis_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic                   push, full, pop, head_valid;
  item_ctl_t              push_ctl, head_ctl;
  logic [COUNT_WIDTH-1:0] push_n, head_n;
  logic [RATIO_WIDTH-1:0] push_q, head_q;
  logic [CW-1:0]          push_sx, push_sy, head_sx, head_sy;
  logic [CW:0]            push_magx, push_magy, head_magx, head_magy;
  logic                   push_negx, push_negy, head_negx, head_negy;

  gis_front #(.CW(CW), .MAXS(MAX_SEGMENTS), .RFB(RATIO_FRAC_BITS)) u_front (
    .in_ch     (in_ch),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_n    (push_n),
    .push_q    (push_q),
    .push_sx   (push_sx),
    .push_sy   (push_sy),
    .push_magx (push_magx),
    .push_magy (push_magy),
    .push_negx (push_negx),
    .push_negy (push_negy),
    .full      (full)
  );

  gis_queue #(.CW(CW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_n     (push_n),
    .push_q     (push_q),
    .push_sx    (push_sx),
    .push_sy    (push_sy),
    .push_magx  (push_magx),
    .push_magy  (push_magy),
    .push_negx  (push_negx),
    .push_negy  (push_negy),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_n     (head_n),
    .head_q     (head_q),
    .head_sx    (head_sx),
    .head_sy    (head_sy),
    .head_magx  (head_magx),
    .head_magy  (head_magy),
    .head_negx  (head_negx),
    .head_negy  (head_negy)
  );

  gis_back #(.CW(CW), .RFB(RATIO_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop        (pop),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_n     (head_n),
    .head_q     (head_q),
    .head_sx    (head_sx),
    .head_sy    (head_sy),
    .head_magx  (head_magx),
    .head_magy  (head_magy),
    .head_negx  (head_negx),
    .head_negy  (head_negy),
    .out_ch     (out_ch)
  );

endmodule
